>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define SMD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define SMD_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/smd_pkg.sv
// ----------------------------------------------------------------------------
// Sorted merge package
// Types, operation codes and defaults shared by the sorted merge block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smd_pkg;

    localparam int LIST_DEPTH_DEF = 16;

    localparam logic [1:0] OP_PUSH_A = 2'd0;
    localparam logic [1:0] OP_PUSH_B = 2'd1;
    localparam logic [1:0] OP_MERGE  = 2'd2;

    typedef struct packed {
        logic [1:0]         operation;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] value_res;
        logic               last;
    } t_out_item;

    // Controller to datapath
    typedef struct packed {
        logic push_a;
        logic push_b;
        logic load;
        logic rd;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic both_empty;
        logic last_pick;
    } t_dp_status;

endpackage

>>> hw/rtl/smd_datapath.sv
// ----------------------------------------------------------------------------
// Sorted merge datapath
// List stores, counts, read cursors, compare and the registered result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_datapath #(
    parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  smd_pkg::t_dp_cmd   i_cmd,
    input  logic signed [31:0] i_value,
    output smd_pkg::t_dp_status o_status,
    output logic               o_res_valid,
    output smd_pkg::t_out_item o_res
);

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int IW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [31:0] mem_a [LIST_DEPTH];
    logic [31:0] mem_b [LIST_DEPTH];

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic [CW-1:0] r_ia, r_ib;
    logic signed [31:0] r_rd_a, r_rd_b;
    logic               r_res_valid;
    smd_pkg::t_out_item r_res;

    logic [CW-1:0] ia_m1, ib_m1;
    logic          take_a;
    logic          last_pick;

    assign ia_m1 = r_ia - CW'(1);
    assign ib_m1 = r_ib - CW'(1);

    // Take A when B is exhausted or A is strictly larger; B wins ties
    assign take_a = (r_ia != '0) && ((r_ib == '0) || (r_rd_a > r_rd_b));
    assign last_pick = take_a ? ((r_ia == CW'(1)) && (r_ib == '0))
                              : ((r_ib == CW'(1)) && (r_ia == '0));

    assign o_status.both_empty = (r_cnt_a == '0) && (r_cnt_b == '0);
    assign o_status.last_pick  = last_pick;

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_a && (r_cnt_a < CW'(LIST_DEPTH))) begin
            mem_a[r_cnt_a[IW-1:0]] <= i_value;
        end
        if (i_cmd.push_b && (r_cnt_b < CW'(LIST_DEPTH))) begin
            mem_b[r_cnt_b[IW-1:0]] <= i_value;
        end
        if (i_cmd.rd && (r_ia != '0)) begin
            r_rd_a <= mem_a[ia_m1[IW-1:0]];
        end
        if (i_cmd.rd && (r_ib != '0)) begin
            r_rd_b <= mem_b[ib_m1[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a     <= '0;
            r_cnt_b     <= '0;
            r_ia        <= '0;
            r_ib        <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.emit;
            // Drop pushes into a full list
            if (i_cmd.push_a && (r_cnt_a < CW'(LIST_DEPTH))) begin
                r_cnt_a <= r_cnt_a + CW'(1);
            end
            if (i_cmd.push_b && (r_cnt_b < CW'(LIST_DEPTH))) begin
                r_cnt_b <= r_cnt_b + CW'(1);
            end
            if (i_cmd.load) begin
                r_ia <= r_cnt_a;
                r_ib <= r_cnt_b;
            end
            if (i_cmd.emit) begin
                if (take_a) begin
                    r_ia <= ia_m1;
                end else begin
                    r_ib <= ib_m1;
                end
                if (last_pick) begin
                    r_cnt_a <= '0;
                    r_cnt_b <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_res.value_res <= take_a ? r_rd_a : r_rd_b;
            r_res.last      <= last_pick;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

>>> hw/rtl/smd_ctrl.sv
// ----------------------------------------------------------------------------
// Sorted merge controller
// Decodes commands and sequences the read and emit steps of a merge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smd_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [1:0]          i_operation,
    input  smd_pkg::t_dp_status i_status,
    output logic                o_busy,
    output smd_pkg::t_dp_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   accept;

    assign accept = i_start && (r_state == S_IDLE);
    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_operation)
                        smd_pkg::OP_PUSH_A: o_cmd.push_a = 1'b1;
                        smd_pkg::OP_PUSH_B: o_cmd.push_b = 1'b1;
                        smd_pkg::OP_MERGE: begin
                            // Nothing stored: no beats at all
                            if (!i_status.both_empty) begin
                                o_cmd.load = 1'b1;
                                n_state    = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state    = i_status.last_pick ? S_IDLE : S_READ;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> hw/rtl/sorted_merge_descending_core.sv
// A push is stored at acceptance and never raises busy; an accepted merge loads the cursors,
// then alternates READ (store read) and EMIT (compare), each beat registered out of EMIT.
// A merge keeps busy high through its READ and EMIT steps; the last beat shows as busy falls.
// Reset (synchronous, active low) clears both counts and the controller; stores keep contents.
// Results are single-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// Sorted merge descending core
// Two ascending list stores merged into one descending stream of result beats.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_merge_descending_core #(
    parameter int LIST_DEPTH = smd_pkg::LIST_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  smd_pkg::t_in_item  i_in,
    output logic               o_res_valid,
    output smd_pkg::t_out_item o_res
);

    smd_pkg::t_dp_cmd    cmd;
    smd_pkg::t_dp_status status;

    smd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_in.operation),
        .i_status    (status),
        .o_busy      (o_busy),
        .o_cmd       (cmd)
    );

    smd_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_in.value),
        .o_status    (status),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

>>> hw/rtl/smd_checker.sv
// ----------------------------------------------------------------------------
// Sorted merge checker
// Port-level timing checks on the core, attached by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module smd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input smd_pkg::t_in_item  i_in,
    input logic               o_res_valid,
    input smd_pkg::t_out_item o_res
);

    `SMD_ASSERT(a_beat_spacing, o_res_valid |=> !o_res_valid, "result beats closer than 2 cycles")
    `SMD_ASSERT(a_push_one_cycle, (i_start && !o_busy && (i_in.operation != smd_pkg::OP_MERGE)) |=> !o_busy, "non-merge command held busy")
    `SMD_ASSERT(a_last_idle, (o_res_valid && o_res.last) |-> !o_busy, "busy still high on last beat")
    `SMD_ASSERT(a_mid_busy, (o_res_valid && !o_res.last) |-> o_busy, "busy fell before last beat")
    `SMD_ASSERT_NEVER(a_no_early_beat, $past(i_start && !o_busy) && o_res_valid, "beat straight after accept")

endmodule

bind sorted_merge_descending_core smd_checker u_smd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_in        (i_in),
    .o_res_valid (o_res_valid),
    .o_res       (o_res)
);

>>> tb/tb_sorted_merge_descending_core.sv
// ----------------------------------------------------------------------------
// Sorted merge descending core testbench
// Loads the two list stores with push beats and fires merge beats. A short
// table of directed beats comes first, then random push sequences, which are
// mostly ascending with random content, plus unsorted runs, overflowing lists
// and stray operation codes. Every result beat is checked against a
// behavioural copy of the two stores and their counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sorted_merge_descending_core;

    localparam int DEPTH       = smd_pkg::LIST_DEPTH_DEF;
    localparam int NUM_BEATS   = 430;
    // A merge emits beats while busy and the sender pauses only between bursts, so a
    // STALL_LIMIT run with neither an input nor a result beat means a hang.
    localparam int STALL_LIMIT = 1000;
    localparam int NUM_REPORTS = 10;

    // Spare operation code: the core must ignore it.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        smd_pkg::t_in_item  item;
        logic               typed;     // expected results written in the row
        logic               has_res;   // row carries one typed result
        smd_pkg::t_out_item res;
    } t_dir_row;

    localparam int NUM_DIR = 23;
    localparam t_dir_row DIR_TAB [NUM_DIR] = '{
        // merge straight after reset: nothing stored, nothing emitted
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b1, 1'b0, '0},
        '{'{OP_UNUSED,          32'hA5A5_5A5A}, 1'b1, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_A, 32'h7FFF_FFFF}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h1234_5678}, 1'b1, 1'b1, '{32'h7FFF_FFFF, 1'b1}},
        '{'{smd_pkg::OP_PUSH_B, 32'h8000_0000}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'hFFFF_FFFF}, 1'b1, 1'b1, '{32'h8000_0000, 1'b1}},
        '{'{smd_pkg::OP_PUSH_A, 32'hFFFF_FFFF}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b1, 1'b1, '{32'hFFFF_FFFF, 1'b1}},
        // equal heads on both lists: B wins
        '{'{smd_pkg::OP_PUSH_A, -32'sd5},       1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_A, 32'sd3},        1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_B, -32'sd5},       1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_B, 32'sd3},        1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b0, 1'b0, '0},
        // list A out of order
        '{'{smd_pkg::OP_PUSH_B, 32'sd0},        1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_A, 32'sd10},       1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_A, -32'sd10},      1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_B, 32'h5555_5555}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b0, 1'b0, '0},
        '{'{OP_UNUSED,          32'hFFFF_FFFF}, 1'b1, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_B, 32'h7FFF_FFFF}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_PUSH_A, 32'h7FFF_FFFF}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b0, 1'b0, '0},
        '{'{smd_pkg::OP_MERGE,  32'h0000_0000}, 1'b1, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               i_start;
    logic               o_busy;
    smd_pkg::t_in_item  i_in;
    logic               o_res_valid;
    smd_pkg::t_out_item o_res;

    sorted_merge_descending_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

    // Shadow of the two stores
    logic signed [31:0] list_a [DEPTH];
    logic signed [31:0] list_b [DEPTH];
    int                 fill_a;
    int                 fill_b;

    smd_pkg::t_out_item merge_run[$];        // beats of the latest merge
    smd_pkg::t_out_item pending_results[$];  // beats still owed by the core
    smd_pkg::t_out_item head_res;

    int burst_left;
    int stall_cycles;
    int errors;
    int beats_sent;
    int n_merges;
    int n_results;
    int n_dropped;
    int n_ties;
    int n_ignored;
    int n_longest;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one accepted beat to the shadow stores; merge beats fill merge_run.
    task automatic predict_merge(input smd_pkg::t_in_item item);
        int                 ia;
        int                 ib;
        smd_pkg::t_out_item r;
        merge_run.delete();
        case (item.operation)
            smd_pkg::OP_PUSH_A: begin
                if (fill_a < DEPTH) begin
                    list_a[fill_a] = item.value;
                    fill_a++;
                end else begin
                    n_dropped++;
                end
            end
            smd_pkg::OP_PUSH_B: begin
                if (fill_b < DEPTH) begin
                    list_b[fill_b] = item.value;
                    fill_b++;
                end else begin
                    n_dropped++;
                end
            end
            smd_pkg::OP_MERGE: begin
                ia = fill_a;
                ib = fill_b;
                n_merges++;
                while (ia > 0 || ib > 0) begin
                    if (ia > 0 && ib > 0 && list_a[ia-1] > list_b[ib-1]) begin
                        r.value_res = list_a[ia-1];
                        ia--;
                    end else if (ib > 0) begin
                        if (ia > 0 && list_a[ia-1] == list_b[ib-1])
                            n_ties++;
                        r.value_res = list_b[ib-1];
                        ib--;
                    end else begin
                        r.value_res = list_a[ia-1];
                        ia--;
                    end
                    r.last = (ia == 0 && ib == 0);
                    merge_run.push_back(r);
                end
                if (merge_run.size() > n_longest)
                    n_longest = merge_run.size();
                fill_a = 0;
                fill_b = 0;
            end
            default: n_ignored++;
        endcase
    endtask

    // Offer one beat, hold it until taken, then log what it should produce.
    task automatic send_beat(input smd_pkg::t_in_item item, input logic typed,
                             input logic has_res, input smd_pkg::t_out_item res);
        if (burst_left == 0) begin
            i_start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        i_start <= 1'b1;
        i_in    <= item;
        do @(posedge i_clk); while (o_busy);
        beats_sent++;
        predict_merge(item);
        if (typed) begin
            if (has_res)
                pending_results.push_back(res);
        end else begin
            foreach (merge_run[k])
                pending_results.push_back(merge_run[k]);
        end
    endtask

    // Hold off the sender until the core has delivered everything owed.
    task automatic drain_results();
        i_start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    function automatic int rand_value(input int unsigned mode);
        case (mode)
            0: return int'($urandom_range(0, 15)) - 8;   // dense, plenty of ties
            1: begin
                case ($urandom_range(0, 4))
                    0: return 32'h7FFF_FFFF;
                    1: return 32'h8000_0000;
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input smd_pkg::t_out_item want,
                                   input smd_pkg::t_out_item got);
        errors++;
        if (errors <= NUM_REPORTS)
            $display("%0t %s: expected value %0d last %0b, got value %0d last %0b",
                     $realtime, what, want.value_res, want.last,
                     got.value_res, got.last);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            n_results++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", '0, o_res);
            end else begin
                head_res = pending_results.pop_front();
                if (o_res.value_res !== head_res.value_res || o_res.last !== head_res.last)
                    report_mismatch("wrong beat", head_res, o_res);
            end
        end
    end

    // Watchdog: count cycles with neither an input nor a result beat
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_res_valid)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        int          lists [2][$];
        int          seq_idx;
        int          count_of [2];
        int          pos;
        int          v;
        int          s;
        int unsigned mode;
        logic        ordered;
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_in         <= '0;
        fill_a       = 0;
        fill_b       = 0;
        burst_left   = 0;
        stall_cycles = 0;
        errors       = 0;
        beats_sent   = 0;
        n_merges     = 0;
        n_results    = 0;
        n_dropped    = 0;
        n_ties       = 0;
        n_ignored    = 0;
        n_longest    = 0;
        seq_idx      = 0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIR_TAB[r])
            send_beat(DIR_TAB[r].item, DIR_TAB[r].typed, DIR_TAB[r].has_res,
                      DIR_TAB[r].res);
        drain_results();

        while (beats_sent < NUM_BEATS) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: any operation code, any value
                repeat ($urandom_range(1, 4))
                    send_beat('{operation: 2'($urandom_range(0, 3)), value: $urandom},
                              1'b0, 1'b0, '0);
            end else begin
                ordered = ($urandom_range(0, 7) != 0);
                mode    = $urandom_range(0, 3);
                for (int side = 0; side < 2; side++) begin
                    lists[side].delete();
                    if (seq_idx == 0)
                        count_of[side] = DEPTH + 2 - side;   // overflow both lists
                    else if ($urandom_range(0, 5) == 0)
                        count_of[side] = $urandom_range(9, DEPTH + 4);
                    else
                        count_of[side] = $urandom_range(0, 8);
                    repeat (count_of[side]) begin
                        v   = rand_value(mode);
                        pos = 0;
                        if (ordered)
                            while (pos < lists[side].size() && lists[side][pos] <= v)
                                pos++;
                        lists[side].insert(pos, v);
                    end
                end
                // interleave the two lists, each kept in push order
                while (lists[0].size() + lists[1].size() > 0) begin
                    if (lists[0].size() == 0)
                        s = 1;
                    else if (lists[1].size() == 0)
                        s = 0;
                    else
                        s = $urandom_range(0, 1);
                    send_beat('{operation: (s == 1) ? smd_pkg::OP_PUSH_B
                                                    : smd_pkg::OP_PUSH_A,
                                value: lists[s].pop_front()}, 1'b0, 1'b0, '0);
                end
                send_beat('{operation: smd_pkg::OP_MERGE, value: $urandom},
                          1'b0, 1'b0, '0);
                if ($urandom_range(0, 7) == 0)
                    send_beat('{operation: smd_pkg::OP_MERGE, value: $urandom},
                              1'b0, 1'b0, '0);
            end
            seq_idx++;
            if (seq_idx == 3 || $urandom_range(0, 11) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d input beats: %0d merges, %0d result beats, longest run %0d",
                 beats_sent, n_merges, n_results, n_longest);
        $display("  %0d pushes dropped on full lists, %0d equal heads, %0d spare codes",
                 n_dropped, n_ties, n_ignored);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
